/* hdl/bucketed_event_queue_assert.svh */
// Assertion macros for the bucketed event queue.
// Used by the top level; no other dependencies.
`ifndef BUCKETED_EVENT_QUEUE_ASSERT_SVH
`define BUCKETED_EVENT_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define BEQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BEQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define BEQ_ASSERT(label, clk, rst_n, prop, msg)
`define BEQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

/* hdl/beq_pkg.sv */
// Package for the bucketed event queue: payload structs, codes, sizes.
// No dependencies.
`timescale 1ns / 1ps
package beq_pkg;
  localparam int unsigned BucketsDef = 16;
  localparam int unsigned EntriesDef = 256;
  localparam int unsigned KeyW = 31;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0, CMD_CANCEL = 2'd1, CMD_POP = 2'd2, CMD_PEEK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_DEAD = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [30:0] event_key;
    logic [31:0] payload;
    logic [7:0]  handle;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  new_handle;
    logic [31:0] head_payload;
    logic [30:0] head_key;
    logic [8:0]  live_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_WALK, S_WALKRD, S_INS, S_INS2, S_INS3, S_HEAD,
    S_UNRD, S_UNLINK, S_UNFIX, S_DONE
  } state_e;
endpackage

/* hdl/beq_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module beq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/bucketed_event_queue.sv */
// Bucketed event queue (hashed timing wheel) over a fixed entry pool.
// Enqueue walks the bucket from its tail past entries with larger or equal keys, then writes
// the new entry, its predecessor or the old head, and, mid-list, its successor.
// One transaction at a time; busy is high while one is in progress and low again when the result shows.
// Reset (async, active low) empties all buckets and the pool; no clearing pass.
// The receiver cannot stall: the result shows for one cycle on done_o.
`timescale 1ns / 1ps
`include "bucketed_event_queue_assert.svh"
module bucketed_event_queue #(
  parameter int unsigned BUCKETS = beq_pkg::BucketsDef,
  parameter int unsigned ENTRIES = beq_pkg::EntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  beq_pkg::req_t req_i,
  output logic          done_o,
  output beq_pkg::rsp_t rsp_o
);
  import beq_pkg::*;

  localparam int unsigned Aw = $clog2(ENTRIES);
  localparam int unsigned Lw = Aw + 1;           // link width, null = ENTRIES
  localparam int unsigned Bw = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [Lw-1:0] Nil = Lw'(ENTRIES);
  // One row per entry: key, payload, next, prev.
  localparam int unsigned Rw = KeyW + 32 + 2 * Lw;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [31:0]     pay;
    logic [Lw-1:0]   nxt;
    logic [Lw-1:0]   prv;
  } row_t;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   done_q, done_d;

  logic [Lw-1:0] idx_q, idx_d;  // entry being linked or unlinked

  // Entry memory.
  logic          e_we;
  logic [Aw-1:0] e_wa, e_ra;
  row_t          e_wd, e_rd;
  beq_ram #(.Width(Rw), .Depth(ENTRIES)) u_entry (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra),
    .rdata_o(e_rd)
  );
  // Free stack memory, read address is the stack top.
  logic          f_we;
  logic [Aw-1:0] f_wa;
  logic [Aw-1:0] f_rd;
  logic [Lw-1:0] cnt_q, cnt_d;
  logic [Lw-1:0] fill_q, fill_d;  // lowest slot written since reset
  beq_ram #(.Width(Aw), .Depth(ENTRIES)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(idx_q[Aw-1:0]),
    .raddr_i(Aw'(ENTRIES - 1 - cnt_q)), .rdata_o(f_rd)
  );

  logic [ENTRIES-1:0] live_q, live_d;
  logic [Lw-1:0] head_q [BUCKETS];
  logic [Lw-1:0] tail_q [BUCKETS];
  logic          hw_en, tw_en;
  logic [Bw-1:0] hb, tb;
  logic [Lw-1:0] hv, tv;

  logic [Lw-1:0] p_q, p_d;      // walk pointer / prev
  logic [Lw-1:0] n_q, n_d;      // next
  row_t          row_q, row_d;
  logic [Bw-1:0] bk_q, bk_d;

  // A slot below the lowest written one was never written, so its index is taken
  // from the live count at the time it becomes the top.
  logic [Aw-1:0] free_idx;
  logic [Lw-1:0] top_slot;
  assign top_slot = Lw'(ENTRIES - 1) - cnt_q;
  assign free_idx = (top_slot < fill_q) ? Aw'(cnt_q) : f_rd;

  function automatic logic [Bw-1:0] bucket_of(input logic [31:0] v);
    return Bw'(v % BUCKETS);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      fill_q  <= Nil;
      live_q  <= '0;
      for (int i = 0; i < BUCKETS; i++) begin
        head_q[i] <= Nil;
        tail_q[i] <= Nil;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      live_q  <= live_d;
      if (hw_en) head_q[hb] <= hv;
      if (tw_en) tail_q[tb] <= tv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    rsp_q    <= rsp_d;
    idx_q    <= idx_d;
    p_q      <= p_d;
    n_q      <= n_d;
    row_q    <= row_d;
    bk_q     <= bk_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_ALLOC;
      S_ALLOC: begin
        unique case (cmd_e'(req_q.cmd))
          CMD_ENQ:    state_d = (cnt_q >= Nil) ? S_DONE : S_WALK;
          CMD_CANCEL: state_d = (req_q.handle < ENTRIES && live_q[Aw'(req_q.handle)])
                                ? S_UNRD : S_DONE;
          default:    state_d = (head_q[bucket_of(req_q.current_time)] == Nil)
                                ? S_DONE : S_HEAD;
        endcase
      end
      S_WALK:   state_d = (p_q == Nil) ? S_INS : S_WALKRD;
      S_WALKRD: state_d = (e_rd.key >= req_q.event_key) ? S_WALK : S_INS;
      S_INS:    state_d = S_INS2;
      S_INS2:   state_d = (p_q != Nil && n_q != Nil) ? S_INS3 : S_DONE;
      S_INS3:   state_d = S_DONE;
      S_HEAD:   state_d = (cmd_e'(req_q.cmd) == CMD_POP) ? S_UNLINK : S_DONE;
      S_UNRD:   state_d = S_UNLINK;
      S_UNLINK: state_d = S_UNFIX;
      S_UNFIX:  state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    rsp_d = rsp_q; done_d = 1'b0;
    cnt_d = cnt_q; fill_d = fill_q; live_d = live_q;
    idx_d = idx_q; p_d = p_q; n_d = n_q; row_d = row_q; bk_d = bk_q;
    e_we = 1'b0; e_wa = '0; e_wd = row_q; e_ra = p_q[Aw-1:0];
    f_we = 1'b0; f_wa = '0;
    hw_en = 1'b0; tw_en = 1'b0; hb = bk_q; tb = bk_q; hv = Nil; tv = Nil;
    unique case (state_q)
      S_IDLE: begin
        rsp_d = '0;
      end
      S_ALLOC: begin
        unique case (cmd_e'(req_q.cmd))
          CMD_ENQ: begin
            if (cnt_q >= Nil) begin
              rsp_d.status = ST_FULL;
            end else begin
              idx_d = {1'b0, free_idx};
              cnt_d = cnt_q + 1'b1;
              live_d[free_idx] = 1'b1;
              bk_d = bucket_of({1'b0, req_q.event_key});
              p_d = tail_q[bucket_of({1'b0, req_q.event_key})];
              rsp_d.new_handle = 8'(free_idx);
              row_d.key = req_q.event_key;
              row_d.pay = req_q.payload;
            end
          end
          CMD_CANCEL: begin
            idx_d = Lw'(req_q.handle);
            e_ra = Aw'(req_q.handle);
            if (!(req_q.handle < ENTRIES && live_q[Aw'(req_q.handle)]))
              rsp_d.status = ST_DEAD;
          end
          default: begin
            bk_d = bucket_of(req_q.current_time);
            idx_d = head_q[bucket_of(req_q.current_time)];
            e_ra = idx_d[Aw-1:0];
            if (idx_d == Nil) begin
              rsp_d.status = ST_EMPTY;
              rsp_d.head_key = '1;
            end
          end
        endcase
      end
      S_WALK: e_ra = p_q[Aw-1:0];
      S_WALKRD: begin
        if (e_rd.key >= req_q.event_key) begin
          p_d = e_rd.prv;
        end else begin
          n_d = e_rd.nxt;
          row_d = e_rd;  // keep predecessor row, rewritten in S_INS2
        end
      end
      S_INS: begin
        // Write the new entry; p_q is its predecessor.
        e_we = 1'b1; e_wa = idx_q[Aw-1:0];
        e_wd.key = req_q.event_key; e_wd.pay = req_q.payload;
        e_wd.prv = p_q;
        e_wd.nxt = (p_q == Nil) ? head_q[bk_q] : n_q;
        n_d = e_wd.nxt;
        if (p_q == Nil) begin
          hw_en = 1'b1; hv = idx_q;
        end
        if (e_wd.nxt == Nil) begin
          tw_en = 1'b1; tv = idx_q;
        end
        e_ra = e_wd.nxt[Aw-1:0];
      end
      S_INS2: begin
        // Fix the predecessor's next, or the old head's prev.
        if (p_q != Nil) begin
          e_we = 1'b1; e_wa = p_q[Aw-1:0];
          e_wd = row_q; e_wd.nxt = idx_q;
          e_ra = n_q[Aw-1:0];
        end else if (n_q != Nil) begin
          e_we = 1'b1; e_wa = n_q[Aw-1:0];
          e_wd = e_rd; e_wd.prv = idx_q;
        end
      end
      S_INS3: begin
        // The new entry sits between two others: fix the successor's prev.
        e_we = 1'b1; e_wa = n_q[Aw-1:0];
        e_wd = e_rd; e_wd.prv = idx_q;
      end
      S_HEAD: begin
        rsp_d.head_key = e_rd.key;
        if (cmd_e'(req_q.cmd) == CMD_POP) begin
          rsp_d.head_payload = e_rd.pay;
          row_d = e_rd;
          e_ra = e_rd.prv[Aw-1:0];
        end
      end
      S_UNRD: begin
        row_d = e_rd;
        bk_d = bucket_of({1'b0, e_rd.key});
        e_ra = e_rd.prv[Aw-1:0];
      end
      S_UNLINK: begin
        // Predecessor row arrives; patch its next, or the bucket head.
        if (row_q.prv != Nil) begin
          e_we = 1'b1; e_wa = row_q.prv[Aw-1:0];
          e_wd = e_rd; e_wd.nxt = row_q.nxt;
        end else begin
          hw_en = 1'b1; hv = row_q.nxt;
        end
        if (row_q.nxt == Nil) begin
          tw_en = 1'b1; tv = row_q.prv;
        end
        e_ra = row_q.nxt[Aw-1:0];
        live_d[idx_q[Aw-1:0]] = 1'b0;
        f_we = 1'b1; f_wa = Aw'(Lw'(ENTRIES) - cnt_q);
        if (Lw'(ENTRIES) - cnt_q < fill_q) fill_d = Lw'(ENTRIES) - cnt_q;
        cnt_d = cnt_q - 1'b1;
      end
      S_UNFIX: begin
        if (row_q.nxt != Nil) begin
          e_we = 1'b1; e_wa = row_q.nxt[Aw-1:0];
          e_wd = e_rd; e_wd.prv = row_q.prv;
        end
      end
      S_DONE: begin
        done_d = 1'b1;
        rsp_d.live_count = 9'(cnt_q);
      end
      default: ;
    endcase
  end

  `BEQ_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= Nil, "live count beyond pool")
  `BEQ_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q, "result held two cycles")
  `BEQ_ASSERT(a_idle_after_done, clk_i, rst_ni, !done_q || state_q == S_IDLE,
              "not idle after result")
endmodule

/* dv/bucketed_event_queue_checker.sv */
// Checker for the bucketed event queue: watches both channels, predicts results, compares.
// Depends on beq_pkg for the request and response structs and the codes.
`timescale 1ns / 1ps
module bucketed_event_queue_checker #(
  parameter int unsigned BUCKETS = beq_pkg::BucketsDef,
  parameter int unsigned ENTRIES = beq_pkg::EntriesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  beq_pkg::req_t  req_i,
  input  logic           done_i,
  input  beq_pkg::rsp_t  rsp_i,
  output int             errors_o,
  output int             pending_o
);
  import beq_pkg::*;

  localparam int unsigned Nil = ENTRIES;

  logic [30:0] key_mem [ENTRIES];
  logic [31:0] pay_mem [ENTRIES];
  logic [9:0]  nxt [ENTRIES];
  logic [9:0]  prv [ENTRIES];
  logic        live [ENTRIES];
  logic [9:0]  head [BUCKETS];
  logic [9:0]  tail [BUCKETS];
  logic [7:0]  free_idx [ENTRIES];
  int unsigned total;
  rsp_t        expected_q[$];

  initial begin
    errors_o = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      live[i] = 1'b0;
      free_idx[i] = 8'(ENTRIES - 1 - i);
    end
    for (int b = 0; b < BUCKETS; b++) begin
      head[b] = 10'(Nil);
      tail[b] = 10'(Nil);
    end
    total = 0;
  end

  assign pending_o = expected_q.size();

  function automatic void link_entry(int unsigned idx);
    int unsigned b, p, n;
    b = key_mem[idx] % BUCKETS;
    p = tail[b];
    while (p != Nil && key_mem[p] >= key_mem[idx]) p = prv[p];
    if (p == Nil) begin
      n = head[b];
      prv[idx] = 10'(Nil);
      head[b] = 10'(idx);
    end else begin
      n = nxt[p];
      prv[idx] = 10'(p);
      nxt[p] = 10'(idx);
    end
    nxt[idx] = 10'(n);
    if (n != Nil) prv[n] = 10'(idx);
    else tail[b] = 10'(idx);
  endfunction

  function automatic void unlink_entry(int unsigned idx);
    int unsigned b, p, n;
    b = key_mem[idx] % BUCKETS;
    p = prv[idx];
    n = nxt[idx];
    if (p != Nil) nxt[p] = 10'(n);
    else head[b] = 10'(n);
    if (n != Nil) prv[n] = 10'(p);
    else tail[b] = 10'(p);
    live[idx] = 1'b0;
    free_idx[ENTRIES - total] = 8'(idx);
    total--;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t o;
    int unsigned idx, h;
    o = '0;
    o.status = ST_OK;
    case (cmd_e'(r.cmd))
      CMD_ENQ: begin
        if (total >= ENTRIES) begin
          o.status = ST_FULL;
        end else begin
          idx = free_idx[ENTRIES - 1 - total];
          total++;
          key_mem[idx] = r.event_key;
          pay_mem[idx] = r.payload;
          live[idx] = 1'b1;
          link_entry(idx);
          o.new_handle = 8'(idx);
        end
      end
      CMD_CANCEL: begin
        if (r.handle < ENTRIES && live[r.handle]) unlink_entry(r.handle);
        else o.status = ST_DEAD;
      end
      default: begin
        h = head[r.current_time % BUCKETS];
        if (h == Nil) begin
          o.status = ST_EMPTY;
          o.head_key = '1;
        end else begin
          o.head_key = key_mem[h];
          if (cmd_e'(r.cmd) == CMD_POP) begin
            o.head_payload = pay_mem[h];
            unlink_entry(h);
          end
        end
      end
    endcase
    o.live_count = 9'(total);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      // Compare first so a result and a new request on one edge keep their order.
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.status != want.status)
            report_mismatch("status", rsp_i.status, want.status);
          if (rsp_i.new_handle != want.new_handle)
            report_mismatch("new_handle", rsp_i.new_handle, want.new_handle);
          if (rsp_i.head_payload != want.head_payload)
            report_mismatch("head_payload", rsp_i.head_payload, want.head_payload);
          if (rsp_i.head_key != want.head_key)
            report_mismatch("head_key", rsp_i.head_key, want.head_key);
          if (rsp_i.live_count != want.live_count)
            report_mismatch("live_count", rsp_i.live_count, want.live_count);
        end
      end
      if (start_i && !busy_i) expected_q.push_back(predict_result(req_i));
    end
  end
endmodule

/* dv/bucketed_event_queue_tb.sv */
// Top of the bucketed event queue testbench: clock, reset, stimulus and verdict.
// Depends on beq_pkg, the block and bucketed_event_queue_checker.
`timescale 1ns / 1ps
module bucketed_event_queue_tb;
  import beq_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done_o;
  req_t req_r = '0;
  rsp_t rsp_o;
  int   errors;
  int   pending;
  int   quiet_cycles = 0;
  bit   idling_on = 1'b1;

  always #5 clk_i = ~clk_i;

  bucketed_event_queue uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_r),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  bucketed_event_queue_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_i   (busy),
    .req_i    (req_r),
    .done_i   (done_o),
    .rsp_i    (rsp_o),
    .errors_o (errors),
    .pending_o(pending)
  );

  // The watchdog restarts whenever a transaction moves in either direction.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(cmd_e c, logic [30:0] k, logic [31:0] p,
                                    logic [7:0] h, logic [31:0] now);
    req_t r;
    r.cmd = c;
    r.event_key = k;
    r.payload = p;
    r.handle = h;
    r.current_time = now;
    return r;
  endfunction

  // Hold start high until the block takes the request; start stays high afterwards
  // so back-to-back requests need no second assignment in the same step.
  task automatic issue(req_t r);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_r <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Keys mostly sit in a narrow range so buckets collect several entries and
  // equal keys, which makes the sorted insert walk far.
  function automatic logic [30:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return 31'($urandom());
      2: return 31'($urandom_range(0, 3)) * 31'd16;
      default: return 31'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic req_t random_req(int enq_weight);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < enq_weight)
      return make_req(CMD_ENQ, pick_key(), $urandom(), 8'($urandom()), $urandom());
    if (sel < enq_weight + (100 - enq_weight) / 3)
      return make_req(CMD_CANCEL, '0, '0,
                      ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 40)),
                      $urandom());
    if (sel < enq_weight + 2 * (100 - enq_weight) / 3)
      return make_req(CMD_POP, '0, '0, '0, $urandom());
    return make_req(CMD_PEEK, '0, '0, '0, $urandom());
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty bucket, key extremes, equal keys, cancel cases.
    issue(make_req(CMD_PEEK, '0, '0, '0, 32'hFFFF_FFFF));
    issue(make_req(CMD_POP, '0, '0, '0, 32'd0));
    issue(make_req(CMD_ENQ, 31'd0, 32'h0000_0000, '0, '0));
    issue(make_req(CMD_ENQ, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, '1));
    issue(make_req(CMD_ENQ, 31'd16, 32'hA5A5_A5A5, '0, '0));
    issue(make_req(CMD_ENQ, 31'd16, 32'h5A5A_5A5A, '0, '0));
    issue(make_req(CMD_ENQ, 31'd32, 32'h1234_5678, '0, '0));
    issue(make_req(CMD_ENQ, 31'd16, 32'h8765_4321, '0, '0));
    issue(make_req(CMD_PEEK, '0, '0, '0, 32'd0));
    issue(make_req(CMD_PEEK, '0, '0, '0, 32'hFFFF_FFFF));
    issue(make_req(CMD_CANCEL, '0, '0, 8'd3, '0));
    issue(make_req(CMD_CANCEL, '0, '0, 8'd3, '0));
    issue(make_req(CMD_CANCEL, '0, '0, 8'hFF, '0));
    issue(make_req(CMD_POP, '0, '0, '0, 32'd16));
    issue(make_req(CMD_POP, '0, '0, '0, 32'h0000_0020));
    issue(make_req(CMD_POP, '0, '0, '0, 32'hFFFF_FFFF));
    issue(make_req(CMD_POP, '0, '0, '0, 32'hFFFF_FFFF));
    issue(make_req(CMD_POP, '0, '0, '0, 32'd0));
    issue(make_req(CMD_POP, '0, '0, '0, 32'd0));
    issue(make_req(CMD_PEEK, '0, '0, '0, 32'd0));

    // Hold off until the block has answered everything so far.
    start <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);

    // Mixed traffic with a balanced mix of commands.
    repeat (60) issue(random_req(40));
    // Enqueue only, past the end of the pool, so the pool-full answer shows up.
    repeat (260) issue(random_req(100));
    // Drain with mostly pops, peeks and cancels, then a final stretch without idling.
    repeat (40) issue(random_req(15));
    idling_on = 1'b0;
    repeat (20) issue(random_req(50));

    start <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
